### rtl/core/lkpc_pkg.sv
// ----------------------------------------------------------------------------
// lkpc_pkg
// shared codes and constants of the lens and keystone position control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lkpc_pkg;

	// position word width, default of the top level parameter
	localparam int POSITION_BITS_DEF = 16;

	// field widths
	localparam int OPCODE_W = 2;
	localparam int BUTTON_W = 2;
	localparam int COUNT_W  = 8;
	localparam int CMD_W    = 2;
	localparam int SPEED_W  = 8;
	localparam int STEP_W   = 4;
	localparam int TARGET_W = 16;
	localparam int TOL_W    = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_BUTTON  = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_ENC_REV = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_ENC_FWD = 2'd3;

	// buttons
	localparam logic [BUTTON_W-1:0] BTN_LEFT   = 2'd0;
	localparam logic [BUTTON_W-1:0] BTN_RIGHT  = 2'd1;
	localparam logic [BUTTON_W-1:0] BTN_MIDDLE = 2'd2;

	// motor commands
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SPEED = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LENS_TARGET     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEYSTONE_TARGET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LENS_TOLERANCE  = 2'd2;

	// drive profile
	localparam int SPEED_MAX       = 75;
	localparam int SPEED_MIN       = 30;
	localparam int LENS_NEAR       = 20;
	localparam int LENS_FAR        = 100;
	localparam int TOLERANCE_RESET = 3;
	localparam int KEYSTONE_STEP   = 5;

	// (m * 45) / 100 as m * ceil(45 * 2^19 / 100) >> 19, exact for m <= 100
	localparam int RECIP_SHIFT = 19;
	localparam int SLOPE_RECIP =
		((SPEED_MAX - SPEED_MIN) * (2 ** RECIP_SHIFT) + LENS_FAR - 1) / LENS_FAR;
	localparam int SLOPE_W     = $clog2(SLOPE_RECIP + 1);
	localparam int MAG_LO_W    = 7;
	localparam int PROD_W      = SLOPE_W + MAG_LO_W;
	localparam int SPD_MAG_W   = 7;

endpackage

### rtl/core/lkpc_speed.sv
// ----------------------------------------------------------------------------
// lkpc_speed
// lens drive speed from the signed distance between position and target
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkpc_speed #(
	parameter int POSITION_BITS = lkpc_pkg::POSITION_BITS_DEF
) (
	input  logic [POSITION_BITS-1:0]             position,
	input  logic signed [lkpc_pkg::TARGET_W-1:0] target,
	input  logic [lkpc_pkg::TOL_W-1:0]           tolerance,
	output logic signed [lkpc_pkg::SPEED_W-1:0]  speed
);

	logic [31:0]                        tgt_ext;
	logic [POSITION_BITS-1:0]           diff;
	logic                               neg;
	logic [POSITION_BITS-1:0]           mag;
	logic [31:0]                        mag_ext;
	logic [lkpc_pkg::PROD_W-1:0]        prod;
	logic [lkpc_pkg::SPD_MAG_W-1:0]     spd_mag;

	always_comb begin
		tgt_ext = 32'(target);
		diff    = position - tgt_ext[POSITION_BITS-1:0];
		neg     = diff[POSITION_BITS-1];
		// the most negative distance maps to its unsigned magnitude
		mag     = neg ? (~diff + 1'b1) : diff;
		mag_ext = 32'(mag);
		prod    = lkpc_pkg::PROD_W'(mag[lkpc_pkg::MAG_LO_W-1:0])
			* lkpc_pkg::PROD_W'(lkpc_pkg::SLOPE_RECIP);

		if (mag_ext <= 32'(tolerance)) begin
			spd_mag = '0;
		end else if (mag_ext <= 32'(lkpc_pkg::LENS_NEAR)) begin
			spd_mag = lkpc_pkg::SPD_MAG_W'(lkpc_pkg::SPEED_MIN);
		end else if (mag_ext <= 32'(lkpc_pkg::LENS_FAR)) begin
			spd_mag = lkpc_pkg::SPD_MAG_W'(prod[lkpc_pkg::PROD_W-1:lkpc_pkg::RECIP_SHIFT])
				+ lkpc_pkg::SPD_MAG_W'(lkpc_pkg::SPEED_MIN);
		end else begin
			spd_mag = lkpc_pkg::SPD_MAG_W'(lkpc_pkg::SPEED_MAX);
		end

		speed = neg ? -lkpc_pkg::SPEED_W'(spd_mag) : lkpc_pkg::SPEED_W'(spd_mag);
	end

endmodule

### rtl/core/lens_keystone_position_control.sv
// ----------------------------------------------------------------------------
// lens_keystone_position_control: lens dc motor and keystone stepper control
// timing: an accepted item goes through the input register, then the result
//   register; a stalled result holds the next item in the input register
// throughput: one item per cycle while out_ready is high, set by the single-pass compute stage
// reset: arst_n clears both modes to homing, positions to zero, registers to
//   their reset values and both pipeline registers to empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lens_keystone_position_control #(
	parameter int POSITION_BITS = lkpc_pkg::POSITION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_write,
	input  logic [lkpc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lkpc_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [lkpc_pkg::OPCODE_W-1:0]         opcode,
	input  logic [lkpc_pkg::BUTTON_W-1:0]         button_id,
	input  logic [lkpc_pkg::COUNT_W-1:0]          move_count,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [lkpc_pkg::CMD_W-1:0]            motor_command,
	output logic signed [lkpc_pkg::SPEED_W-1:0]   motor_speed,
	output logic signed [lkpc_pkg::STEP_W-1:0]    stepper_move
);

	// configuration registers
	logic signed [lkpc_pkg::TARGET_W-1:0] lens_target_q;
	logic signed [lkpc_pkg::TARGET_W-1:0] keystone_target_q;
	logic [lkpc_pkg::TOL_W-1:0]           lens_tolerance_q;

	// control state
	logic [POSITION_BITS-1:0] lens_position_q;
	logic                     lens_running_q;
	logic [POSITION_BITS-1:0] keystone_position_q;
	logic                     keystone_running_q;

	// input register
	logic                            valid_s1;
	logic [lkpc_pkg::OPCODE_W-1:0]   opcode_s1;
	logic [lkpc_pkg::BUTTON_W-1:0]   button_s1;
	logic [lkpc_pkg::COUNT_W-1:0]    count_s1;

	// result register
	logic                                 out_valid_q;
	logic [lkpc_pkg::CMD_W-1:0]           command_q;
	logic signed [lkpc_pkg::SPEED_W-1:0]  speed_q;
	logic signed [lkpc_pkg::STEP_W-1:0]   step_q;

	// handshake
	logic advance;
	logic accept;

	// single-pass compute
	logic signed [lkpc_pkg::SPEED_W-1:0]  lens_speed;
	logic [31:0]                          ktgt_ext;
	logic [lkpc_pkg::CMD_W-1:0]           command_d;
	logic signed [lkpc_pkg::SPEED_W-1:0]  speed_d;
	logic signed [lkpc_pkg::STEP_W-1:0]   step_d;
	logic [POSITION_BITS-1:0]             lens_position_d;
	logic                                 lens_running_d;
	logic [POSITION_BITS-1:0]             keystone_position_d;
	logic                                 keystone_running_d;

	// the input register drains whenever the result register is free or
	// being emptied, so a new item is taken while a result waits
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign accept   = in_valid && in_ready;

	// configuration writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_target_q     <= '0;
			keystone_target_q <= '0;
			lens_tolerance_q  <= lkpc_pkg::TOL_W'(lkpc_pkg::TOLERANCE_RESET);
		end else if (cfg_write) begin
			case (cfg_index)
				lkpc_pkg::REG_LENS_TARGET:     lens_target_q     <= cfg_data;
				lkpc_pkg::REG_KEYSTONE_TARGET: keystone_target_q <= cfg_data;
				lkpc_pkg::REG_LENS_TOLERANCE:  lens_tolerance_q  <= cfg_data[lkpc_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	// input register: valid resets, payload does not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			button_s1 <= button_id;
			count_s1  <= move_count;
		end
	end

	// drive speed from lens distance
	lkpc_speed #(
		.POSITION_BITS(POSITION_BITS)
	) u_speed (
		.position  (lens_position_q),
		.target    (lens_target_q),
		.tolerance (lens_tolerance_q),
		.speed     (lens_speed)
	);

	always_comb begin
		ktgt_ext            = 32'(keystone_target_q);
		command_d           = lkpc_pkg::CMD_NONE;
		speed_d             = '0;
		step_d              = '0;
		lens_position_d     = lens_position_q;
		lens_running_d      = lens_running_q;
		keystone_position_d = keystone_position_q;
		keystone_running_d  = keystone_running_q;

		case (opcode_s1)
			lkpc_pkg::OP_TICK: begin
				// tick while homing gives no action
				if (lens_running_q) begin
					command_d = lkpc_pkg::CMD_SPEED;
					speed_d   = lens_speed;
					// keystone only moves while the lens sits within tolerance
					if (lens_speed == '0) begin
						if (!keystone_running_q) begin
							step_d = lkpc_pkg::STEP_W'(lkpc_pkg::KEYSTONE_STEP);
						end else if ($signed(keystone_position_q)
							> $signed(ktgt_ext[POSITION_BITS-1:0])) begin
							step_d = lkpc_pkg::STEP_W'(lkpc_pkg::KEYSTONE_STEP);
							keystone_position_d = keystone_position_q
								- POSITION_BITS'(lkpc_pkg::KEYSTONE_STEP);
						end else if ($signed(keystone_position_q)
							< $signed(ktgt_ext[POSITION_BITS-1:0])) begin
							step_d = -lkpc_pkg::STEP_W'(lkpc_pkg::KEYSTONE_STEP);
							keystone_position_d = keystone_position_q
								+ POSITION_BITS'(lkpc_pkg::KEYSTONE_STEP);
						end
					end
				end
			end
			lkpc_pkg::OP_BUTTON: begin
				case (button_s1)
					lkpc_pkg::BTN_RIGHT: begin
						// first press ends homing, later presses zero the position
						if (lens_running_q) begin
							lens_position_d = '0;
						end else begin
							lens_running_d = 1'b1;
						end
						command_d = lkpc_pkg::CMD_STOP;
					end
					lkpc_pkg::BTN_MIDDLE: begin
						keystone_running_d = 1'b1;
					end
					default: ;
				endcase
			end
			default: begin
				// encoder movement, ignored while homing
				if (lens_running_q) begin
					if (opcode_s1 inside {lkpc_pkg::OP_ENC_REV}) begin
						lens_position_d = lens_position_q + POSITION_BITS'(count_s1);
					end else begin
						lens_position_d = lens_position_q - POSITION_BITS'(count_s1);
					end
				end
			end
		endcase
	end

	// state commits when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_position_q     <= '0;
			lens_running_q      <= 1'b0;
			keystone_position_q <= '0;
			keystone_running_q  <= 1'b0;
		end else if (advance) begin
			lens_position_q     <= lens_position_d;
			lens_running_q      <= lens_running_d;
			keystone_position_q <= keystone_position_d;
			keystone_running_q  <= keystone_running_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			command_q <= command_d;
			speed_q   <= speed_d;
			step_q    <= step_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign motor_command = command_q;
	assign motor_speed   = speed_q;
	assign stepper_move  = step_q;

endmodule

### rtl/core/lkpc_checker.sv
// ----------------------------------------------------------------------------
// lkpc_checker
// port-level checks on the result channel of the position control
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lkpc_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [lkpc_pkg::CMD_W-1:0]           motor_command,
	input logic signed [lkpc_pkg::SPEED_W-1:0]  motor_speed,
	input logic signed [lkpc_pkg::STEP_W-1:0]   stepper_move
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(motor_command)
			&& $stable(motor_speed) && $stable(stepper_move))
		else $error("result changed while stalled");

	// speed and step only travel with a set-speed command
	a_speed_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_command != lkpc_pkg::CMD_SPEED |-> motor_speed == '0
			&& stepper_move == '0)
		else $error("speed or step without set-speed command");

	// keystone steps only while the lens drive is zero
	a_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_speed != '0 |-> stepper_move == '0)
		else $error("keystone stepped while lens moving");

	// speed profile bound
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> motor_speed <= 8'sd75 && motor_speed >= -8'sd75)
		else $error("speed out of range");

	// step is zero or one full step either way
	a_step_vals: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stepper_move == 4'sd0 || stepper_move == 4'sd5
			|| stepper_move == -4'sd5)
		else $error("bad stepper move");

endmodule

bind lens_keystone_position_control lkpc_checker u_lkpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.motor_command (motor_command),
	.motor_speed   (motor_speed),
	.stepper_move  (stepper_move)
);

### verif/lens_keystone_position_control_tb.sv
// ----------------------------------------------------------------------------
// lens_keystone_position_control_tb
// self-checking bench: a scoreboard class predicts motor command, lens speed
// and stepper move for every input transaction and compares each output
// transaction in order; directed items first, then phases of random
// traffic under several register settings, mostly with random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lens_keystone_position_control_tb;

	// position width of the instance under test
	localparam int POS_W = lkpc_pkg::POSITION_BITS_DEF;

	// drive profile and stepper size, kept apart from the package values
	localparam int SPD_TOP      = 75;
	localparam int SPD_FLOOR    = 30;
	localparam int NEAR_BAND    = 20;
	localparam int FAR_BAND     = 100;
	localparam int KS_STEP_SIZE = 5;

	// button code with no button behind it
	localparam logic [lkpc_pkg::BUTTON_W-1:0] BTN_UNUSED = 2'd3;

	// run length
	localparam int PHASES         = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int SETTLE_CYCLES  = 6;
	localparam int CYCLE_LIMIT    = 900000;

	// percent of draws with no gap, sender and receiver
	localparam int SEND_BUSY_PCT = 65;
	localparam int RECV_BUSY_PCT = 70;

	typedef logic [POS_W-1:0] pos_t;

	typedef struct {
		logic [lkpc_pkg::CMD_W-1:0]          command;
		logic signed [lkpc_pkg::SPEED_W-1:0] speed;
		logic signed [lkpc_pkg::STEP_W-1:0]  step;
	} drive_result_t;

	// ------------------------------------------------------------------------
	// predicts the drive for each transaction and checks results in order
	// ------------------------------------------------------------------------
	class motor_drive_scoreboard;
		pos_t                       lens_pos;
		pos_t                       ks_pos;
		bit                         lens_run;
		bit                         ks_run;
		logic [15:0]                lens_tgt;
		logic [15:0]                ks_tgt;
		logic [lkpc_pkg::TOL_W-1:0] tol;
		drive_result_t              pending_drives[$];
		int                         errors;
		int                         results_seen;

		function new();
			lens_pos     = '0;
			ks_pos       = '0;
			lens_run     = 1'b0;
			ks_run       = 1'b0;
			lens_tgt     = '0;
			ks_tgt       = '0;
			tol          = lkpc_pkg::TOL_W'(3);
			errors       = 0;
			results_seen = 0;
		endfunction

		function int pending();
			return pending_drives.size();
		endfunction

		function void set_reg(logic [lkpc_pkg::CFG_IDX_W-1:0] idx,
				logic [lkpc_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				lkpc_pkg::REG_LENS_TARGET:     lens_tgt = data[15:0];
				lkpc_pkg::REG_KEYSTONE_TARGET: ks_tgt   = data[15:0];
				lkpc_pkg::REG_LENS_TOLERANCE:  tol      = data[lkpc_pkg::TOL_W-1:0];
				default: ;
			endcase
		endfunction

		// signed speed toward the lens target
		function longint lens_drive_speed();
			pos_t   gap_pos;
			longint offset;
			longint mag;
			longint spd;
			gap_pos = lens_pos - pos_t'($signed(lens_tgt));
			offset = $signed(gap_pos);
			mag = (offset < 0) ? -offset : offset;
			if (mag <= longint'(tol))
				spd = 0;
			else if (mag <= NEAR_BAND)
				spd = SPD_FLOOR;
			else if (mag <= FAR_BAND)
				spd = (mag * (SPD_TOP - SPD_FLOOR)) / 100 + SPD_FLOOR;
			else
				spd = SPD_TOP;
			return (offset < 0) ? -spd : spd;
		endfunction

		function void note_item(logic [lkpc_pkg::OPCODE_W-1:0] op,
				logic [lkpc_pkg::BUTTON_W-1:0] btn, logic [lkpc_pkg::COUNT_W-1:0] cnt);
			drive_result_t r;
			longint        spd;
			longint        cur;
			longint        tgt;
			r.command = lkpc_pkg::CMD_NONE;
			r.speed   = '0;
			r.step    = '0;
			case (op)
				lkpc_pkg::OP_TICK: if (lens_run) begin
					spd = lens_drive_speed();
					r.command = lkpc_pkg::CMD_SPEED;
					r.speed   = spd[lkpc_pkg::SPEED_W-1:0];
					if (spd == 0) begin
						if (!ks_run) begin
							r.step = lkpc_pkg::STEP_W'(KS_STEP_SIZE);
						end else begin
							cur = $signed(ks_pos);
							tgt = $signed(pos_t'($signed(ks_tgt)));
							if (cur > tgt) begin
								r.step = lkpc_pkg::STEP_W'(KS_STEP_SIZE);
								ks_pos = ks_pos - pos_t'(KS_STEP_SIZE);
							end else if (cur < tgt) begin
								r.step = -lkpc_pkg::STEP_W'(KS_STEP_SIZE);
								ks_pos = ks_pos + pos_t'(KS_STEP_SIZE);
							end
						end
					end
				end
				lkpc_pkg::OP_BUTTON: begin
					if (btn == lkpc_pkg::BTN_RIGHT) begin
						if (lens_run)
							lens_pos = '0;
						else
							lens_run = 1'b1;
						r.command = lkpc_pkg::CMD_STOP;
					end
					if (btn == lkpc_pkg::BTN_MIDDLE)
						ks_run = 1'b1;
				end
				lkpc_pkg::OP_ENC_REV: if (lens_run) lens_pos = lens_pos + cnt;
				default:              if (lens_run) lens_pos = lens_pos - cnt;
			endcase
			pending_drives.push_back(r);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			errors++;
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
		endtask

		task check_drive(logic [lkpc_pkg::CMD_W-1:0] cmd,
				logic signed [lkpc_pkg::SPEED_W-1:0] spd,
				logic signed [lkpc_pkg::STEP_W-1:0] stp);
			drive_result_t want;
			results_seen++;
			if (pending_drives.size() == 0) begin
				report_mismatch("unexpected transaction, command", cmd, 0);
			end else begin
				want = pending_drives.pop_front();
				if (cmd !== want.command)
					report_mismatch("motor_command", cmd, want.command);
				if (spd !== want.speed)
					report_mismatch("motor_speed", spd, want.speed);
				if (stp !== want.step)
					report_mismatch("stepper_move", stp, want.step);
			end
		endtask
	endclass

	// ------------------------------------------------------------------------
	// block under test
	// ------------------------------------------------------------------------
	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_write;
	logic [lkpc_pkg::CFG_IDX_W-1:0]       cfg_index;
	logic [lkpc_pkg::CFG_DATA_W-1:0]      cfg_data;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [lkpc_pkg::OPCODE_W-1:0]        opcode;
	logic [lkpc_pkg::BUTTON_W-1:0]        button_id;
	logic [lkpc_pkg::COUNT_W-1:0]         move_count;
	logic                                 out_valid;
	logic                                 out_ready;
	logic [lkpc_pkg::CMD_W-1:0]           motor_command;
	logic signed [lkpc_pkg::SPEED_W-1:0]  motor_speed;
	logic signed [lkpc_pkg::STEP_W-1:0]   stepper_move;

	motor_drive_scoreboard sb;
	bit idle_on;

	lens_keystone_position_control dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.button_id     (button_id),
		.move_count    (move_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.motor_command (motor_command),
		.motor_speed   (motor_speed),
		.stepper_move  (stepper_move)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// gap length: mostly none, some short, a few long; none while idling is off
	function automatic int pick_gap(int busy_pct);
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < busy_pct)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// one input transaction; the prediction is made at the accepting edge
	task automatic send_item(input logic [lkpc_pkg::OPCODE_W-1:0] op,
			input logic [lkpc_pkg::BUTTON_W-1:0] btn,
			input logic [lkpc_pkg::COUNT_W-1:0] cnt);
		int gap;
		gap = pick_gap(SEND_BUSY_PCT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		button_id  <= btn;
		move_count <= cnt;
		do @(posedge clk); while (!in_ready);
		sb.note_item(op, btn, cnt);
	endtask

	// tick with random unused fields
	task automatic send_tick();
		send_item(lkpc_pkg::OP_TICK, lkpc_pkg::BUTTON_W'($urandom_range(0, 3)),
			lkpc_pkg::COUNT_W'($urandom_range(0, 255)));
	endtask

	task automatic send_press(input logic [lkpc_pkg::BUTTON_W-1:0] btn);
		send_item(lkpc_pkg::OP_BUTTON, btn, lkpc_pkg::COUNT_W'($urandom_range(0, 255)));
	endtask

	task automatic send_move(input logic [lkpc_pkg::OPCODE_W-1:0] op,
			input logic [lkpc_pkg::COUNT_W-1:0] cnt);
		send_item(op, lkpc_pkg::BUTTON_W'($urandom_range(0, 3)), cnt);
	endtask

	// random traffic: ticks, presses, and encoder moves that often steer the
	// lens back near its target so every band of the profile gets hit
	task automatic send_random_item();
		int     r;
		int     b;
		pos_t   aim;
		longint delta;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			send_tick();
		end else if (r < 52) begin
			b = $urandom_range(0, 9);
			if (b < 3)
				send_press(lkpc_pkg::BTN_RIGHT);
			else if (b < 5)
				send_press(lkpc_pkg::BTN_MIDDLE);
			else if (b < 8)
				send_press(lkpc_pkg::BTN_LEFT);
			else
				send_press(BTN_UNUSED);
		end else if ($urandom_range(0, 2) == 0) begin
			aim = pos_t'($signed(sb.lens_tgt)) + pos_t'(int'($urandom_range(0, 60)) - 30);
			delta = $signed(pos_t'(aim - sb.lens_pos));
			if (delta >= 0)
				send_move(lkpc_pkg::OP_ENC_REV,
					lkpc_pkg::COUNT_W'((delta > 255) ? 255 : delta));
			else
				send_move(lkpc_pkg::OP_ENC_FWD,
					lkpc_pkg::COUNT_W'((-delta > 255) ? 255 : -delta));
		end else begin
			send_move($urandom_range(0, 1) ? lkpc_pkg::OP_ENC_REV : lkpc_pkg::OP_ENC_FWD,
				($urandom_range(0, 9) < 7) ? lkpc_pkg::COUNT_W'($urandom_range(0, 40))
				                           : lkpc_pkg::COUNT_W'($urandom_range(0, 255)));
		end
	endtask

	// drop valid and wait until every predicted result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// back-to-back register writes, only while the block is idle
	task automatic program_regs(input logic [15:0] lt, input logic [15:0] kt,
			input logic [lkpc_pkg::CFG_DATA_W-1:0] tw);
		cfg_write <= 1'b1;
		cfg_index <= lkpc_pkg::REG_LENS_TARGET;
		cfg_data  <= lt;
		@(posedge clk);
		cfg_index <= lkpc_pkg::REG_KEYSTONE_TARGET;
		cfg_data  <= kt;
		@(posedge clk);
		cfg_index <= lkpc_pkg::REG_LENS_TOLERANCE;
		cfg_data  <= tw;
		@(posedge clk);
		cfg_write <= 1'b0;
		sb.set_reg(lkpc_pkg::REG_LENS_TARGET, lt);
		sb.set_reg(lkpc_pkg::REG_KEYSTONE_TARGET, kt);
		sb.set_reg(lkpc_pkg::REG_LENS_TOLERANCE, tw);
	endtask

	// ------------------------------------------------------------------------
	// result side: checks every output transaction, random stalls on ready
	// ------------------------------------------------------------------------
	initial begin : result_sink
		int stall_left;
		int n;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_drive(motor_command, motor_speed, stepper_move);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				n = pick_gap(RECV_BUSY_PCT);
				if (n > 0) begin
					out_ready <= 1'b0;
					stall_left = n - 1;
				end else begin
					out_ready <= 1'b1;
				end
			end
		end
	end

	// hard stop for a hung handshake
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		logic [15:0]                     lt;
		logic [15:0]                     kt;
		logic [lkpc_pkg::CFG_DATA_W-1:0] tw;
		arst_n     = 1'b0;
		cfg_write  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		opcode     = '0;
		button_id  = '0;
		move_count = '0;
		out_ready  = 1'b0;
		idle_on    = 1'b1;
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed, reset register values: target 0, tolerance 3
		send_tick();                                // lens homing, no action
		send_move(lkpc_pkg::OP_ENC_REV, 8'd255);    // ignored while homing
		send_press(lkpc_pkg::BTN_LEFT);
		send_press(BTN_UNUSED);
		send_press(lkpc_pkg::BTN_RIGHT);            // homing to run, stop
		send_tick();                                // on target, keystone homing steps
		send_move(lkpc_pkg::OP_ENC_REV, 8'd3);
		send_tick();                                // right at the tolerance edge
		send_move(lkpc_pkg::OP_ENC_REV, 8'd1);
		send_tick();                                // just past tolerance, floor speed
		send_move(lkpc_pkg::OP_ENC_REV, 8'd16);
		send_tick();                                // top of the near band
		send_move(lkpc_pkg::OP_ENC_REV, 8'd1);
		send_tick();                                // bottom of the linear band
		send_move(lkpc_pkg::OP_ENC_REV, 8'd79);
		send_tick();                                // top of the linear band
		send_move(lkpc_pkg::OP_ENC_REV, 8'd1);
		send_tick();                                // far band
		send_move(lkpc_pkg::OP_ENC_FWD, 8'd255);
		send_tick();                                // far band, negative side
		send_press(lkpc_pkg::BTN_RIGHT);            // run: zero the position, stop
		send_press(lkpc_pkg::BTN_MIDDLE);           // keystone to run
		send_tick();                                // keystone already on target
		send_press(lkpc_pkg::BTN_MIDDLE);           // ignored once running
		wait_drained();

		// random phases under different settings, extremes first
		for (int phase = 0; phase < PHASES; phase++) begin
			tw = lkpc_pkg::CFG_DATA_W'($urandom);
			case (phase)
				0: begin
					lt = 16'h8000;            // position 0 sits at the most negative distance
					kt = 16'h0000;
					tw[lkpc_pkg::TOL_W-1:0] = '0;
				end
				1: begin
					lt = 16'h0000;
					kt = 16'h7fff;
					tw[lkpc_pkg::TOL_W-1:0] = '1;
				end
				2: begin
					lt = 16'h7fff;
					kt = 16'h8000;
					tw[lkpc_pkg::TOL_W-1:0] = lkpc_pkg::TOL_W'(3);
				end
				3: begin
					lt = 16'h0000;
					kt = 16'h8000;
					tw[lkpc_pkg::TOL_W-1:0] = '1;
				end
				default: begin
					lt = 16'($urandom_range(0, 300) - 150);
					kt = 16'($urandom_range(0, 400) - 200);
					tw[lkpc_pkg::TOL_W-1:0] = ($urandom_range(0, 1) != 0)
						? lkpc_pkg::TOL_W'($urandom_range(0, 20))
						: lkpc_pkg::TOL_W'($urandom_range(20, 255));
				end
			endcase
			program_regs(lt, kt, tw);
			// one phase in four runs with no idling on either side
			idle_on = (phase % 4) != 3;
			send_tick();
			repeat (ITEMS_PER_PHASE) send_random_item();
			wait_drained();
		end

		if (sb.errors == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### sim.f
rtl/core/lkpc_pkg.sv
rtl/core/lkpc_speed.sv
rtl/core/lens_keystone_position_control.sv
rtl/core/lkpc_checker.sv
verif/lens_keystone_position_control_tb.sv
